/* src/dwmd_pkg.sv */
// Shared types and constants for the distinct-window marker detector.
package dwmd_pkg;

  localparam int SEQ_BITS     = 64;
  localparam int BYTE_BITS    = 8;
  localparam int TAB_DEPTH    = 256;
  localparam int CFG_BITS     = 5;
  localparam int POS_OUT_BITS = 32;
  localparam int STAT_BITS    = 2;

  localparam logic [CFG_BITS-1:0] LEN_RESET = 5'd4;

  typedef logic [SEQ_BITS-1:0]  seq_t;
  typedef logic [BYTE_BITS-1:0] byte_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_SEARCH  = 2'd0,
    ST_FOUND   = 2'd1,
    ST_EARLIER = 2'd2
  } status_t;

  // Write request into the last-seen table
  typedef struct packed {
    logic  en;
    byte_t addr;
    seq_t  seq;
  } tab_wr_t;

  // Registered read result of the last-seen table
  typedef struct packed {
    logic hit;
    seq_t seq;
  } tab_rd_t;

endpackage

/* src/dwmd_table.sv */
// Last-seen table: sequence stamp of the latest occurrence of each byte value.
module dwmd_table
  import dwmd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    rd_en,
  input  byte_t   rd_addr,
  input  tab_wr_t wr,
  output tab_rd_t rd
);

  seq_t                 mem [TAB_DEPTH];
  logic [TAB_DEPTH-1:0] vld;
  seq_t                 mem_q;
  seq_t                 byp_seq;
  logic                 vld_q;
  logic                 byp_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.seq;
    end
    if (rd_en) begin
      mem_q   <= mem[rd_addr];
      byp_seq <= wr.seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
      byp_q <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= vld[rd_addr];
        // read and write of the same entry in one cycle: take the new stamp
        byp_q <= wr.en && (wr.addr == rd_addr);
      end
    end
  end

  assign rd.hit = byp_q | vld_q;
  assign rd.seq = byp_q ? byp_seq : mem_q;

endmodule

/* src/dwmd_track.sv */
// Run tracker: distinct-suffix length, found flag, position and output register.
module dwmd_track
  import dwmd_pkg::*;
#(
  parameter int WINDOW_MAX    = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_fire,
  input  byte_t                   in_byte,
  input  logic                    in_start,
  output logic                    in_ready,
  input  logic [CFG_BITS-1:0]     window_len,
  input  tab_rd_t                 rd,
  output tab_wr_t                 wr,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [POS_OUT_BITS-1:0] out_position,
  output status_t                 out_status
);

  localparam int DW = $clog2(WINDOW_MAX + 1);
  localparam int CW = (DW > CFG_BITS) ? DW : CFG_BITS;
  localparam int PW = (POSITION_BITS > POS_OUT_BITS) ? POSITION_BITS : POS_OUT_BITS;
  localparam logic [CW:0] WIN_MAX_W = (CW + 1)'(WINDOW_MAX);

  logic                     s1_valid;
  byte_t                    s1_byte;
  logic                     s1_start;
  logic [DW-1:0]            run;
  logic                     seen;
  logic [POSITION_BITS-1:0] pos;
  seq_t                     seq;

  logic                     s1_adv;
  logic [DW-1:0]            run_base;
  logic                     seen_base;
  logic [POSITION_BITS-1:0] pos_base;
  logic [POSITION_BITS-1:0] pos_next;
  logic [PW-1:0]            pos_wide;
  seq_t                     stamp_gap;
  logic                     near;
  logic [CW:0]              run_inc;
  logic [CW:0]              run_new;
  logic [CW:0]              run_cap;
  logic [CW:0]              len_raw;
  logic [CW:0]              len_eff;
  logic                     marker;
  status_t                  status_next;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  // a stream start clears the state before this byte is taken
  assign run_base  = s1_start ? '0 : run;
  assign seen_base = s1_start ? 1'b0 : seen;
  assign pos_base  = s1_start ? '0 : pos;

  assign pos_next = (pos_base == '1) ? pos_base : pos_base + 1'b1;
  assign pos_wide = PW'(pos_next);

  // byte repeats inside the current distinct run when its last stamp is close enough
  assign stamp_gap = seq - rd.seq;
  assign near      = rd.hit && (stamp_gap <= seq_t'(run_base));
  assign run_inc   = (CW + 1)'(run_base) + 1'b1;
  assign run_new   = near ? {1'b0, stamp_gap[CW-1:0]} : run_inc;
  assign run_cap   = (run_new > WIN_MAX_W) ? WIN_MAX_W : run_new;

  always_comb begin
    len_raw = (CW + 1)'(window_len);
    len_eff = len_raw;
    if (len_raw == '0) begin
      len_eff = (CW + 1)'(1);
    end else if (len_raw > WIN_MAX_W) begin
      len_eff = WIN_MAX_W;
    end
  end

  assign marker = run_cap >= len_eff;

  always_comb begin
    if (seen_base) begin
      status_next = ST_EARLIER;
    end else if (marker) begin
      status_next = ST_FOUND;
    end else begin
      status_next = ST_SEARCH;
    end
  end

  // stamp the byte only while searching
  assign wr.en   = s1_adv && !seen_base;
  assign wr.addr = s1_byte;
  assign wr.seq  = seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      run       <= '0;
      seen      <= 1'b0;
      pos       <= '0;
      seq       <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
        run       <= run_cap[DW-1:0];
        seen      <= seen_base | marker;
        pos       <= pos_next;
        seq       <= seq + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte  <= in_byte;
      s1_start <= in_start;
    end
    if (s1_adv) begin
      out_position <= pos_wide[POS_OUT_BITS-1:0];
      out_status   <= status_next;
    end
  end

endmodule

/* src/distinct_window_marker_detect_unit.sv */
// Top level of the distinct-window marker detector.
//
// Scans a byte stream for the first point where the newest window_len bytes
// are all different. Each byte transfer on the slave side gives exactly one
// result on the master side: the one-based, saturating position of the byte
// in its stream and a status (searching, marker completed here, marker found
// earlier). A set stream-start flag clears the stream state before its byte
// is counted as byte one. Throughput is one byte per clock while the master
// side accepts results; a result goes through the synchronous read of the
// last-seen table and then through the output register. The table holds, for
// each of the 256 byte values, a 64-bit sequence stamp of its latest
// occurrence; a byte extends the current run of distinct bytes unless its
// stamp lies inside that run, so no window compare over many entries is
// needed. A byte that repeats in the very next transfer is caught by a bypass
// around the table. Table entries carry valid flags cleared by reset, so there
// is no clearing pass. The user writes window_len through cfg_wr_en/cfg_wr_data
// only while the block is idle; the block does not enforce it. It takes effect
// from the next byte. Zero acts as one, values above WINDOW_MAX as WINDOW_MAX.
module distinct_window_marker_detect_unit
  import dwmd_pkg::*;
#(
  parameter int WINDOW_MAX    = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_BITS-1:0]     cfg_wr_data,   // window_len
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [BYTE_BITS-1:0]    s_axis_tdata,  // [7:0] stream_byte
  input  logic                    s_axis_tuser,  // [0] stream_start
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [POS_OUT_BITS-1:0] m_axis_tdata,  // [31:0] position
  output logic [STAT_BITS-1:0]    m_axis_tuser   // [1:0] status
);

  logic [CFG_BITS-1:0] window_len;
  logic                in_fire;
  tab_wr_t             tab_wr;
  tab_rd_t             tab_rd;
  status_t             status;

  // hold the window length between configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= LEN_RESET;
    end else if (cfg_wr_en) begin
      window_len <= cfg_wr_data;
    end
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  // the table read is issued with the transfer and lines up with the tracker stage
  dwmd_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (s_axis_tdata),
    .wr      (tab_wr),
    .rd      (tab_rd)
  );

  dwmd_track #(
    .WINDOW_MAX    (WINDOW_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_track (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .in_byte      (s_axis_tdata),
    .in_start     (s_axis_tuser),
    .in_ready     (s_axis_tready),
    .window_len   (window_len),
    .rd           (tab_rd),
    .wr           (tab_wr),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_position (m_axis_tdata),
    .out_status   (status)
  );

  assign m_axis_tuser = status;

endmodule

/* src/dwmd_checker.sv */
// Port-level checks for the distinct-window marker detector, bound to the top level.
module dwmd_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wr_en,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a fresh result follows an earlier byte transfer
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching byte transfer");

  // an empty output side never blocks the input
  a_no_idle_block: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output is empty");

  // positions start at one and the status code is defined
  a_result_form: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata != 32'd0) && (m_axis_tuser != 2'd3))
    else $error("malformed result");

  // window_len changes only while no byte is offered and no result waits
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |-> !s_axis_tvalid && !m_axis_tvalid)
    else $error("window_len written while busy");

endmodule

bind distinct_window_marker_detect_unit dwmd_checker u_dwmd_checker (.*);

/* dv/tb_distinct_window_marker_detect_unit.sv */
// Self-checking testbench for the distinct-window marker detector top level.
module tb_distinct_window_marker_detect_unit
  import dwmd_pkg::*;
;

  localparam int WIN_MAX    = 16;
  localparam int POS_BITS   = 32;
  localparam int CYCLE_CAP  = 400000;  // far beyond the slowest legal run
  localparam int PHASE_ITEMS = 72;     // random transfers per window setting

  // Predicts position and status per byte and holds the verdicts in flight.
  class marker_scoreboard;
    typedef struct {
      logic [POS_BITS-1:0] pos;
      status_t             st;
    } verdict_t;

    byte_t               win [WIN_MAX];
    int unsigned         fill;
    logic [POS_BITS-1:0] pos;
    bit                  seen;
    logic [CFG_BITS-1:0] wlen;
    verdict_t            verdict_q [$];
    int unsigned         errors;
    int unsigned         results;
    int unsigned         markers;

    function new();
      clear_stream();
      wlen    = LEN_RESET;
      errors  = 0;
      results = 0;
      markers = 0;
    endfunction

    function void clear_stream();
      foreach (win[i]) win[i] = '0;
      fill = 0;
      pos  = '0;
      seen = 1'b0;
    endfunction

    function void set_len(logic [CFG_BITS-1:0] v);
      wlen = v;
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    // Work out the verdict for one accepted byte and queue it.
    function void note_byte(byte_t b, logic first);
      verdict_t v;
      int unsigned eff;
      bit distinct;
      if (first) clear_stream();
      if (pos != '1) pos++;
      if (seen) begin
        v.st = ST_EARLIER;
      end else begin
        eff = (wlen < 1) ? 1 : ((wlen > WIN_MAX) ? WIN_MAX : wlen);
        for (int i = WIN_MAX - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = b;
        if (fill < WIN_MAX) fill++;
        distinct = 1'b1;
        for (int i = 0; i < eff; i++)
          for (int j = 0; j < i; j++)
            if (win[i] == win[j]) distinct = 1'b0;
        if (fill >= eff && distinct) begin
          seen = 1'b1;
          v.st = ST_FOUND;
        end else begin
          v.st = ST_SEARCH;
        end
      end
      v.pos = pos;
      verdict_q.push_back(v);
    endfunction

    function void check_result(logic [POS_BITS-1:0] p, logic [STAT_BITS-1:0] s);
      verdict_t v;
      results++;
      if (verdict_q.size() == 0) begin
        report($sformatf("result pos=%0d status=%0d with nothing expected", p, s));
        return;
      end
      v = verdict_q.pop_front();
      if (p !== v.pos)
        report($sformatf("position %0d, expected %0d", p, v.pos));
      if (s !== v.st)
        report($sformatf("status %0d at position %0d, expected %0d", s, v.pos, v.st));
      if (s === ST_FOUND) markers++;
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    cfg_wr_en;
  logic [CFG_BITS-1:0]     cfg_wr_data;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [BYTE_BITS-1:0]    s_axis_tdata;
  logic                    s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [POS_OUT_BITS-1:0] m_axis_tdata;
  logic [STAT_BITS-1:0]    m_axis_tuser;

  marker_scoreboard sb = new();

  int unsigned cycles      = 0;
  int unsigned bytes_in    = 0;
  int unsigned settings    = 0;
  int unsigned burst_left  = 0;
  int unsigned rx_tick     = 0;
  int unsigned rx_hold     = 0;

  distinct_window_marker_detect_unit #(
    .WINDOW_MAX    (WIN_MAX),
    .POSITION_BITS (POS_BITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: abandon the run once the total cycle count passes CYCLE_CAP.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d verdicts still pending", cycles, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sample both handshakes at the rising edge; note the input transfer first.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_byte(s_axis_tdata, s_axis_tuser);
        bytes_in++;
      end
      if (m_axis_tvalid === 1'b1 && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // Receiver back-pressure: rotate through four stall patterns in turn,
  // the first of them never stalling.
  always @(negedge clk) begin
    rx_tick++;
    if (rx_hold != 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_tick / 256) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ((rx_tick % 5) != 0 && (rx_tick % 7) != 3);
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            rx_hold = $urandom_range(1, 10);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Offer one byte and hold it until the transfer; end on a falling edge.
  // Bursts of random length are separated by random gaps, sometimes none.
  task automatic send_byte(input byte_t b, input logic first);
    int unsigned gap;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    @(negedge clk);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Drop valid, wait for every verdict to arrive, then let the pipe settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write window_len while idle; it applies from the next byte.
  task automatic write_len(input logic [CFG_BITS-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_len(v);
    settings++;
  endtask

  // One random phase: mostly well-formed streams over a narrow alphabet sized
  // around the window, so searches run long; some stray bytes and restarts.
  task automatic random_phase(input logic [CFG_BITS-1:0] len);
    int unsigned sent;
    int unsigned eff;
    int unsigned asize;
    int unsigned slen;
    int unsigned base;
    byte_t       b;
    logic        first;
    drain();
    write_len(len);
    sent = 0;
    eff  = (len < 1) ? 1 : ((len > WIN_MAX) ? WIN_MAX : len);
    while (sent < PHASE_ITEMS) begin
      asize = $urandom_range((eff > 1) ? eff - 1 : 1, eff + 6);
      slen  = $urandom_range(1, 3 * eff + 10);
      base  = $urandom_range(0, 255);
      for (int k = 0; k < slen && sent < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 9) == 0)
          b = byte_t'($urandom_range(0, 255));
        else
          b = byte_t'(base + $urandom_range(0, asize - 1));
        // Most streams open with the start flag; a few run on without one.
        first = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
        send_byte(b, first);
        sent++;
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Bytes ahead of any start flag continue the stream begun at reset; the
    // repeat holds off the marker, which then completes on the fifth byte.
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h55, 1'b0);  // after the marker: counted only
    send_byte(8'hFF, 1'b0);
    // Fresh stream with alternating repeats.
    send_byte(8'hAA, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h33, 1'b0);
    // Zero length acts as one: the first byte of a stream is a marker.
    drain();
    write_len(5'd0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h80, 1'b0);
    // Length change mid-stream: the shorter window completes on the next byte.
    drain();
    write_len(5'd8);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h11, 1'b0);
    drain();
    write_len(5'd2);
    send_byte(8'h33, 1'b0);

    // Random phases, extremes first; lengths past the window maximum clamp.
    random_phase(5'd16);
    random_phase(5'd31);
    random_phase(5'd1);
    random_phase(5'd17);
    random_phase(5'd0);
    random_phase(5'd2);
    random_phase(5'd15);
    random_phase(5'd8);
    random_phase(5'd5);
    random_phase(5'($urandom_range(0, 31)));
    random_phase(5'($urandom_range(0, 31)));

    drain();
    repeat (10) @(negedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d verdicts never arrived", sb.pending()));

    $display("covered %0d byte transfers under %0d window_len settings", bytes_in, settings);
    $display("checked %0d results, %0d markers completed", sb.results, sb.markers);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
